[hdl/tea_pkg.sv]
package tea_pkg;

    // Field widths
    localparam int TYPE_W  = 16;
    localparam int CODE_W  = 16;
    localparam int VALUE_W = 32;
    localparam int SIZE_W  = 14;
    localparam int POS_W   = 13;
    localparam int BTN_W   = 3;

    // Configuration port
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 1'b1;

    // Event types and codes
    localparam logic [TYPE_W-1:0] TYPE_SYN = 16'h0000;
    localparam logic [TYPE_W-1:0] TYPE_KEY = 16'h0001;
    localparam logic [TYPE_W-1:0] TYPE_ABS = 16'h0003;

    localparam logic [CODE_W-1:0] CODE_AXIS_X     = 16'h0000;
    localparam logic [CODE_W-1:0] CODE_AXIS_Y     = 16'h0001;
    localparam logic [CODE_W-1:0] CODE_KEY_LEFT   = 16'h0110;
    localparam logic [CODE_W-1:0] CODE_KEY_RIGHT  = 16'h0111;
    localparam logic [CODE_W-1:0] CODE_KEY_MIDDLE = 16'h0112;
    localparam logic [CODE_W-1:0] CODE_REPORT     = 16'h0000;

    localparam logic [BTN_W-1:0] MASK_LEFT   = 3'b001;
    localparam logic [BTN_W-1:0] MASK_RIGHT  = 3'b010;
    localparam logic [BTN_W-1:0] MASK_MIDDLE = 3'b100;

    // Reset values and limits
    localparam logic [SIZE_W-1:0] RESET_WIDTH  = 14'd1024;
    localparam logic [SIZE_W-1:0] RESET_HEIGHT = 14'd768;
    localparam logic [POS_W-1:0]  RESET_X      = 13'd512;
    localparam logic [POS_W-1:0]  RESET_Y      = 13'd384;
    localparam logic [POS_W-1:0]  POS_LIMIT    = 13'd8191;

    localparam int AXIS_MAX_DEF = 32767;

    // Decoded operation that travels down the pipeline with each item
    typedef struct packed {
        logic             axis_x;
        logic             axis_y;
        logic             key_wr;
        logic [BTN_W-1:0] key_mask;
        logic             key_press;
        logic             report;
    } t_op;

endpackage

[hdl/tea_front.sv]
module tea_front
    import tea_pkg::*;
#(
    parameter int AXIS_MAX = AXIS_MAX_DEF,
    parameter int PROD_W   = $clog2(AXIS_MAX + 1) + SIZE_W
) (
    input  logic                      i_clk,
    input  logic                      i_load,
    input  logic                      i_adv,
    input  logic [TYPE_W-1:0]         i_ev_type,
    input  logic [CODE_W-1:0]         i_ev_code,
    input  logic signed [VALUE_W-1:0] i_ev_value,
    input  logic [SIZE_W-1:0]         i_width,
    input  logic [SIZE_W-1:0]         i_height,
    output t_op                       o_op,
    output logic [PROD_W-1:0]         o_prod
);

    localparam int AXIS_W = $clog2(AXIS_MAX + 1);

    logic [TYPE_W-1:0]  r_type;
    logic [CODE_W-1:0]  r_code;
    logic [VALUE_W-1:0] r_value;
    t_op                r_op;
    logic [PROD_W-1:0]  r_prod;

    t_op                n_op;
    logic [PROD_W-1:0]  n_prod;
    logic [AXIS_W-1:0]  clamped;
    logic [SIZE_W-1:0]  size;
    logic [SIZE_W-1:0]  span;

    // Decode type and code
    always_comb begin
        n_op = '0;
        n_op.key_press = (r_value != '0);
        case (r_type)
            TYPE_ABS: begin
                n_op.axis_x = (r_code == CODE_AXIS_X);
                n_op.axis_y = (r_code == CODE_AXIS_Y);
            end
            TYPE_KEY: begin
                case (r_code)
                    CODE_KEY_LEFT:   n_op.key_mask = MASK_LEFT;
                    CODE_KEY_RIGHT:  n_op.key_mask = MASK_RIGHT;
                    CODE_KEY_MIDDLE: n_op.key_mask = MASK_MIDDLE;
                    default:         n_op.key_mask = '0;
                endcase
                n_op.key_wr = (n_op.key_mask != '0);
            end
            TYPE_SYN: begin
                n_op.report = (r_code == CODE_REPORT);
            end
            default: begin
                n_op = '0;
            end
        endcase
    end

    // Clamp position, pick span, multiply
    always_comb begin
        if (r_value[VALUE_W-1]) begin
            clamped = '0;
        end else if (r_value[VALUE_W-2:0] > (VALUE_W-1)'(AXIS_MAX)) begin
            clamped = AXIS_W'(AXIS_MAX);
        end else begin
            clamped = r_value[AXIS_W-1:0];
        end
        size   = (r_code == CODE_AXIS_X) ? i_width : i_height;
        span   = (size == '0) ? '0 : size - SIZE_W'(1);
        n_prod = PROD_W'(clamped) * PROD_W'(span);
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_type  <= i_ev_type;
            r_code  <= i_ev_code;
            r_value <= i_ev_value;
        end
        if (i_adv) begin
            r_op   <= n_op;
            r_prod <= n_prod;
        end
    end

    assign o_op   = r_op;
    assign o_prod = r_prod;

endmodule

[hdl/tea_div.sv]
module tea_div
    import tea_pkg::*;
#(
    parameter int AXIS_MAX = AXIS_MAX_DEF,
    parameter int PROD_W   = $clog2(AXIS_MAX + 1) + SIZE_W,
    parameter int REM_W    = $clog2(AXIS_MAX + 1) + 1
) (
    input  logic               i_clk,
    input  logic               i_adv1,
    input  logic               i_adv2,
    input  t_op                i_op,
    input  logic [PROD_W-1:0]  i_prod,
    output t_op                o_op,
    output logic [SIZE_W-1:0]  o_quot,
    output logic [REM_W-1:0]   o_rem
);

    // Estimate floor(p / AXIS_MAX) by a truncated reciprocal; the estimate
    // is low by at most one, fixed after the remainder is known.
    localparam longint unsigned RECIP = (64'd1 << PROD_W) / AXIS_MAX;
    localparam int RECIP_W = $clog2(RECIP + 1);
    localparam int MUL_W   = PROD_W + RECIP_W;

    t_op               r_op2;
    logic [PROD_W-1:0] r_prod2;
    logic [SIZE_W-1:0] r_quot2;
    t_op               r_op3;
    logic [SIZE_W-1:0] r_quot3;
    logic [REM_W-1:0]  r_rem3;

    logic [MUL_W-1:0]  est;
    logic [PROD_W-1:0] back;
    logic [PROD_W-1:0] rem;

    always_comb begin
        est  = MUL_W'(i_prod) * MUL_W'(RECIP);
        back = PROD_W'(r_quot2) * PROD_W'(AXIS_MAX);
        rem  = r_prod2 - back;
    end

    always_ff @(posedge i_clk) begin
        if (i_adv1) begin
            r_op2   <= i_op;
            r_prod2 <= i_prod;
            r_quot2 <= est[PROD_W +: SIZE_W];
        end
        if (i_adv2) begin
            r_op3   <= r_op2;
            r_quot3 <= r_quot2;
            r_rem3  <= rem[REM_W-1:0];
        end
    end

    assign o_op   = r_op3;
    assign o_quot = r_quot3;
    assign o_rem  = r_rem3;

endmodule

[hdl/tea_state.sv]
module tea_state
    import tea_pkg::*;
#(
    parameter int AXIS_MAX = AXIS_MAX_DEF,
    parameter int REM_W    = $clog2(AXIS_MAX + 1) + 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  t_op               i_op,
    input  logic [SIZE_W-1:0] i_quot,
    input  logic [REM_W-1:0]  i_rem,
    output logic [POS_W-1:0]  o_pos_x,
    output logic [POS_W-1:0]  o_pos_y,
    output logic [BTN_W-1:0]  o_buttons,
    output logic              o_committed
);

    logic [POS_W-1:0] r_shown_x, r_shown_y, r_stg_x, r_stg_y;
    logic [BTN_W-1:0] r_shown_btn, r_stg_btn;
    logic             r_stg_valid, r_committed;

    logic [POS_W-1:0] n_shown_x, n_shown_y, n_stg_x, n_stg_y;
    logic [BTN_W-1:0] n_shown_btn, n_stg_btn;
    logic             n_stg_valid, n_committed;

    logic [SIZE_W:0]  quot;
    logic [POS_W-1:0] pos;

    always_comb begin
        // Final quotient correction and saturation
        quot = {1'b0, i_quot} + (SIZE_W+1)'(i_rem >= REM_W'(AXIS_MAX));
        pos  = (quot > (SIZE_W+1)'(POS_LIMIT)) ? POS_LIMIT : quot[POS_W-1:0];

        n_stg_x     = i_op.axis_x ? pos : r_stg_x;
        n_stg_y     = i_op.axis_y ? pos : r_stg_y;
        n_stg_btn   = r_stg_btn;
        if (i_op.key_wr) begin
            n_stg_btn = i_op.key_press ? (r_stg_btn | i_op.key_mask)
                                       : (r_stg_btn & ~i_op.key_mask);
        end
        n_stg_valid = r_stg_valid | i_op.axis_x | i_op.axis_y | i_op.key_wr;

        n_shown_x   = r_shown_x;
        n_shown_y   = r_shown_y;
        n_shown_btn = r_shown_btn;
        n_committed = 1'b0;
        if (i_op.report && r_stg_valid) begin
            n_shown_x   = r_stg_x;
            n_shown_y   = r_stg_y;
            n_shown_btn = r_stg_btn;
            n_stg_valid = 1'b0;
            n_committed = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shown_x   <= RESET_X;
            r_shown_y   <= RESET_Y;
            r_shown_btn <= '0;
            r_stg_x     <= RESET_X;
            r_stg_y     <= RESET_Y;
            r_stg_btn   <= '0;
            r_stg_valid <= 1'b0;
            r_committed <= 1'b0;
        end else if (i_adv) begin
            r_shown_x   <= n_shown_x;
            r_shown_y   <= n_shown_y;
            r_shown_btn <= n_shown_btn;
            r_stg_x     <= n_stg_x;
            r_stg_y     <= n_stg_y;
            r_stg_btn   <= n_stg_btn;
            r_stg_valid <= n_stg_valid;
            r_committed <= n_committed;
        end
    end

    // Shown state only moves when a new result loads, so it is the result
    assign o_pos_x     = r_shown_x;
    assign o_pos_y     = r_shown_y;
    assign o_buttons   = r_shown_btn;
    assign o_committed = r_committed;

endmodule

[hdl/tablet_event_accumulator_core.sv]
// Path: an accepted item passes the input, product, estimate, remainder and
//   result/state registers; each multiplier stage has its own register.
// Throughput: one item per cycle while the output is not stalled.
// Reset (synchronous, active low): empties the pipeline, sets screen size to
//   1024x768, shown and staged positions to 512/384, buttons to 0.
module tablet_event_accumulator_core
    import tea_pkg::*;
#(
    parameter int AXIS_MAX = AXIS_MAX_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,

    // Event items in
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [TYPE_W-1:0]         i_ev_type,
    input  logic [CODE_W-1:0]         i_ev_code,
    input  logic signed [VALUE_W-1:0] i_ev_value,

    // Result items out
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [POS_W-1:0]          o_pos_x,
    output logic [POS_W-1:0]          o_pos_y,
    output logic [BTN_W-1:0]          o_buttons,
    output logic                      o_committed,

    // Configuration writes
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [SIZE_W-1:0]         i_cfg_data
);

    localparam int AXIS_W = $clog2(AXIS_MAX + 1);
    localparam int PROD_W = AXIS_W + SIZE_W;
    localparam int REM_W  = AXIS_W + 1;
    localparam int STAGES = 4;

    // Screen size registers
    logic [SIZE_W-1:0] r_width, r_height;

    // Stage occupancy: 0 input, 1 product, 2 estimate, 3 remainder
    logic [STAGES-1:0] r_vld, n_vld, mv;
    logic              r_out_valid, n_out_valid;
    logic              accept;

    t_op               s1_op, s3_op;
    logic [PROD_W-1:0] s1_prod;
    logic [SIZE_W-1:0] s3_quot;
    logic [REM_W-1:0]  s3_rem;

    // Advance a stage when the one ahead is empty or moving on too, so bubbles
    // collapse and a waiting result holds the front only when every stage is full.
    always_comb begin
        mv[3] = r_vld[3] && (!r_out_valid || !i_stall);
        mv[2] = r_vld[2] && (!r_vld[3] || mv[3]);
        mv[1] = r_vld[1] && (!r_vld[2] || mv[2]);
        mv[0] = r_vld[0] && (!r_vld[1] || mv[1]);

        o_stall = r_vld[0] && !mv[0];
        accept  = i_valid && !o_stall;

        n_vld[0] = (r_vld[0] && !mv[0]) || accept;
        n_vld[1] = (r_vld[1] && !mv[1]) || mv[0];
        n_vld[2] = (r_vld[2] && !mv[2]) || mv[1];
        n_vld[3] = (r_vld[3] && !mv[3]) || mv[2];
        n_out_valid = (r_out_valid && i_stall) || mv[3];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_out_valid <= 1'b0;
            r_width     <= RESET_WIDTH;
            r_height    <= RESET_HEIGHT;
        end else begin
            r_vld       <= n_vld;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_SCREEN_WIDTH:  r_width  <= i_cfg_data;
                    CFG_SCREEN_HEIGHT: r_height <= i_cfg_data;
                    default:           r_width  <= r_width;
                endcase
            end
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_out_valid;

    // Decode, clamp and scale multiply
    tea_front #(
        .AXIS_MAX (AXIS_MAX),
        .PROD_W   (PROD_W)
    ) u_front (
        .i_clk      (i_clk),
        .i_load     (accept),
        .i_adv      (mv[0]),
        .i_ev_type  (i_ev_type),
        .i_ev_code  (i_ev_code),
        .i_ev_value (i_ev_value),
        .i_width    (r_width),
        .i_height   (r_height),
        .o_op       (s1_op),
        .o_prod     (s1_prod)
    );

    // Divide by the axis range: reciprocal estimate, then remainder
    tea_div #(
        .AXIS_MAX (AXIS_MAX),
        .PROD_W   (PROD_W),
        .REM_W    (REM_W)
    ) u_div (
        .i_clk  (i_clk),
        .i_adv1 (mv[1]),
        .i_adv2 (mv[2]),
        .i_op   (s1_op),
        .i_prod (s1_prod),
        .o_op   (s3_op),
        .o_quot (s3_quot),
        .o_rem  (s3_rem)
    );

    // Staged and shown state; the shown state is the result register
    tea_state #(
        .AXIS_MAX (AXIS_MAX),
        .REM_W    (REM_W)
    ) u_state (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (mv[3]),
        .i_op        (s3_op),
        .i_quot      (s3_quot),
        .i_rem       (s3_rem),
        .o_pos_x     (o_pos_x),
        .o_pos_y     (o_pos_y),
        .o_buttons   (o_buttons),
        .o_committed (o_committed)
    );

    // Only a sync report item may commit
    a_commit_only_on_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mv[3] && !s3_op.report) |=> !o_committed)
        else $error("commit flagged for a non-report item");

    // The front only holds off new items when its input register is occupied
    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_vld[0])
        else $error("input stalled with an empty input register");

    // An item leaving the last stage always lands in the result register
    a_result_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mv[3] |=> o_valid)
        else $error("result lost between last stage and output");

endmodule

[tb/testbench.sv]
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import tea_pkg::*;

    // Event types and codes that the block has to ignore
    localparam logic [TYPE_W-1:0] TYPE_REL        = 16'h0002;
    localparam logic [CODE_W-1:0] CODE_AXIS_Z     = 16'h0002;
    localparam logic [CODE_W-1:0] CODE_KEY_SIDE   = 16'h0113;
    localparam logic [CODE_W-1:0] CODE_SYN_CONFIG = 16'h0001;

    // Directed rows either carry a hand-computed result or defer to the predictor
    localparam logic ROW_TYPED     = 1'b1;
    localparam logic ROW_PREDICTED = 1'b0;

    localparam int HOLD_CYCLES     = 80;    // long receiver hold-off, fills the pipeline
    localparam int SETTLE_CYCLES   = 8;     // settle margin after the last owed report
    localparam int WATCHDOG_LIMIT  = 2000;  // cycles with no handshake at all
    localparam int ITEMS_PER_PHASE = 105;
    localparam int SHOWN_MISMATCH  = 10;

    typedef struct packed {
        logic [TYPE_W-1:0]         typ;
        logic [CODE_W-1:0]         code;
        logic signed [VALUE_W-1:0] value;
    } t_ev;

    typedef struct packed {
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_y;
        logic [BTN_W-1:0] buttons;
        logic             committed;
    } t_report;

    typedef struct packed {
        logic [TYPE_W-1:0]  typ;
        logic [CODE_W-1:0]  code;
        logic [VALUE_W-1:0] value;
        logic               typed;
        logic [POS_W-1:0]   x;
        logic [POS_W-1:0]   y;
        logic [BTN_W-1:0]   btn;
        logic               cmt;
    } t_row;

    // Directed events, run at the reset screen size of 1024x768.
    // Typed rows are read straight off the behavior: ignored events, an empty
    // report, clamping at both ends, and full-scale commits.
    localparam t_row DIRECTED [24] = '{
        // unknown type after reset: shown state is the reset state
        '{TYPE_REL, 16'h0000, 32'h0000_0005, ROW_TYPED, 13'd512, 13'd384, 3'd0, 1'b0},
        // report with nothing staged: no commit
        '{TYPE_SYN, CODE_REPORT, 32'h0, ROW_TYPED, 13'd512, 13'd384, 3'd0, 1'b0},
        // full-scale X, most negative Y, left press: staged only
        '{TYPE_ABS, CODE_AXIS_X, 32'h0000_7FFF, ROW_TYPED, 13'd512, 13'd384, 3'd0, 1'b0},
        '{TYPE_ABS, CODE_AXIS_Y, 32'h8000_0000, ROW_TYPED, 13'd512, 13'd384, 3'd0, 1'b0},
        '{TYPE_KEY, CODE_KEY_LEFT, 32'h0000_0001, ROW_TYPED, 13'd512, 13'd384, 3'd0, 1'b0},
        // commit, then a second report finds nothing staged
        '{TYPE_SYN, CODE_REPORT, 32'h0, ROW_TYPED, 13'd1023, 13'd0, 3'd1, 1'b1},
        '{TYPE_SYN, CODE_REPORT, 32'h0, ROW_TYPED, 13'd1023, 13'd0, 3'd1, 1'b0},
        // largest positive X clamps to full scale
        '{TYPE_ABS, CODE_AXIS_X, 32'h7FFF_FFFF, ROW_TYPED, 13'd1023, 13'd0, 3'd1, 1'b0},
        '{TYPE_ABS, CODE_AXIS_Y, 32'h0000_7FFF, ROW_TYPED, 13'd1023, 13'd0, 3'd1, 1'b0},
        // any nonzero value presses, negative ones too
        '{TYPE_KEY, CODE_KEY_RIGHT, 32'hFFFF_FFFF, ROW_TYPED, 13'd1023, 13'd0, 3'd1, 1'b0},
        '{TYPE_KEY, CODE_KEY_MIDDLE, 32'h8000_0000, ROW_TYPED, 13'd1023, 13'd0, 3'd1, 1'b0},
        // unknown codes within known types
        '{TYPE_SYN, CODE_SYN_CONFIG, 32'h0, ROW_TYPED, 13'd1023, 13'd0, 3'd1, 1'b0},
        '{TYPE_ABS, CODE_AXIS_Z, 32'h0000_0064, ROW_TYPED, 13'd1023, 13'd0, 3'd1, 1'b0},
        '{TYPE_KEY, CODE_KEY_SIDE, 32'h0000_0001, ROW_TYPED, 13'd1023, 13'd0, 3'd1, 1'b0},
        '{TYPE_SYN, CODE_REPORT, 32'h0, ROW_TYPED, 13'd1023, 13'd767, 3'd7, 1'b1},
        '{TYPE_KEY, CODE_KEY_LEFT, 32'h0, ROW_TYPED, 13'd1023, 13'd767, 3'd7, 1'b0},
        // mid-scale and near-zero positions, then mixed events, left to the predictor
        '{TYPE_ABS, CODE_AXIS_X, 32'h0000_4000, ROW_PREDICTED, 13'd0, 13'd0, 3'd0, 1'b0},
        '{TYPE_ABS, CODE_AXIS_Y, 32'h0000_0001, ROW_PREDICTED, 13'd0, 13'd0, 3'd0, 1'b0},
        '{16'hFFFF, 16'hFFFF, 32'h7FFF_FFFF, ROW_PREDICTED, 13'd0, 13'd0, 3'd0, 1'b0},
        '{TYPE_SYN, CODE_REPORT, 32'h0, ROW_PREDICTED, 13'd0, 13'd0, 3'd0, 1'b0},
        '{TYPE_ABS, CODE_AXIS_X, 32'hFFFF_FFFF, ROW_PREDICTED, 13'd0, 13'd0, 3'd0, 1'b0},
        '{TYPE_KEY, CODE_KEY_RIGHT, 32'h0, ROW_PREDICTED, 13'd0, 13'd0, 3'd0, 1'b0},
        '{TYPE_SYN, 16'hFFFF, 32'hFFFF_FFFF, ROW_PREDICTED, 13'd0, 13'd0, 3'd0, 1'b0},
        '{TYPE_SYN, CODE_REPORT, 32'h0, ROW_PREDICTED, 13'd0, 13'd0, 3'd0, 1'b0}
    };

    // Block ports; every input starts at a known value
    logic                      i_clk       = 1'b0;
    logic                      i_rst_n     = 1'b0;
    logic                      i_valid     = 1'b0;
    logic                      o_stall;
    logic [TYPE_W-1:0]         i_ev_type   = '0;
    logic [CODE_W-1:0]         i_ev_code   = '0;
    logic signed [VALUE_W-1:0] i_ev_value  = '0;
    logic                      o_valid;
    logic                      i_stall     = 1'b0;
    logic [POS_W-1:0]          o_pos_x;
    logic [POS_W-1:0]          o_pos_y;
    logic [BTN_W-1:0]          o_buttons;
    logic                      o_committed;
    logic                      i_cfg_valid = 1'b0;
    logic                      o_cfg_ready;
    logic [CFG_IDX_W-1:0]      i_cfg_index = '0;
    logic [SIZE_W-1:0]         i_cfg_data  = '0;

    // Predictor copy of the screen size and pointer state
    logic [SIZE_W-1:0] screen_w    = RESET_WIDTH;
    logic [SIZE_W-1:0] screen_h    = RESET_HEIGHT;
    logic [POS_W-1:0]  disp_x      = RESET_X;
    logic [POS_W-1:0]  disp_y      = RESET_Y;
    logic [BTN_W-1:0]  disp_btn    = '0;
    logic [POS_W-1:0]  pend_x      = RESET_X;
    logic [POS_W-1:0]  pend_y      = RESET_Y;
    logic [BTN_W-1:0]  pend_btn    = '0;
    logic              pend_flag   = 1'b0;

    t_report     reports_due [$];
    int unsigned items_sent   = 0;
    int unsigned mismatches   = 0;
    int unsigned quiet_cycles = 0;
    int unsigned gap_pct      = 0;
    bit          hold_req     = 1'b0;
    bit          calm         = 1'b0;

    tablet_event_accumulator_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_ev_type   (i_ev_type),
        .i_ev_code   (i_ev_code),
        .i_ev_value  (i_ev_value),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_pos_x     (o_pos_x),
        .o_pos_y     (o_pos_y),
        .o_buttons   (o_buttons),
        .o_committed (o_committed),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Clamp to 0..AXIS_MAX, scale to the screen span, saturate to 13 bits.
    // A zero size behaves like a size of one: everything maps to pixel 0.
    function automatic logic [POS_W-1:0] scale_to_pixels(logic signed [VALUE_W-1:0] raw,
                                                         logic [SIZE_W-1:0] size);
        longint unsigned pos;
        longint unsigned span;
        longint unsigned pix;
        if (raw < 0) begin
            pos = 0;
        end else if (raw > AXIS_MAX_DEF) begin
            pos = AXIS_MAX_DEF;
        end else begin
            pos = longint'(raw);
        end
        span = (size == '0) ? 0 : longint'(size) - 1;
        pix  = pos * span / AXIS_MAX_DEF;
        if (pix > POS_LIMIT) begin
            pix = POS_LIMIT;
        end
        return pix[POS_W-1:0];
    endfunction

    // Advance the pointer state by one event and return the report it yields
    function automatic t_report track_pointer(t_ev ev);
        t_report          rep;
        logic [BTN_W-1:0] mask;
        rep.committed = 1'b0;
        mask          = '0;
        case (ev.typ)
            TYPE_ABS: begin
                if (ev.code == CODE_AXIS_X) begin
                    pend_x    = scale_to_pixels(ev.value, screen_w);
                    pend_flag = 1'b1;
                end else if (ev.code == CODE_AXIS_Y) begin
                    pend_y    = scale_to_pixels(ev.value, screen_h);
                    pend_flag = 1'b1;
                end
            end
            TYPE_KEY: begin
                case (ev.code)
                    CODE_KEY_LEFT:   mask = MASK_LEFT;
                    CODE_KEY_RIGHT:  mask = MASK_RIGHT;
                    CODE_KEY_MIDDLE: mask = MASK_MIDDLE;
                    default:         mask = '0;
                endcase
                if (mask != '0) begin
                    pend_btn  = (ev.value != 0) ? (pend_btn | mask) : (pend_btn & ~mask);
                    pend_flag = 1'b1;
                end
            end
            TYPE_SYN: begin
                if (ev.code == CODE_REPORT && pend_flag) begin
                    disp_x        = pend_x;
                    disp_y        = pend_y;
                    disp_btn      = pend_btn;
                    pend_flag     = 1'b0;
                    rep.committed = 1'b1;
                end
            end
            default: ;
        endcase
        rep.pos_x   = disp_x;
        rep.pos_y   = disp_y;
        rep.buttons = disp_btn;
        return rep;
    endfunction

    // Offer one event, hold it until taken, then record the report it owes.
    // Valid stays high into the next event unless an idle burst is drawn.
    task automatic send_event(t_ev ev, logic typed, t_report typed_rep);
        t_report due;
        i_valid    <= 1'b1;
        i_ev_type  <= ev.typ;
        i_ev_code  <= ev.code;
        i_ev_value <= ev.value;
        @(posedge i_clk);
        while (o_stall !== 1'b0) @(posedge i_clk);
        due = track_pointer(ev);
        reports_due.push_back(typed ? typed_rep : due);
        items_sent++;
        if (!calm && $urandom_range(99) < gap_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(14, 1)) @(posedge i_clk);
        end
    endtask

    task automatic post(logic [TYPE_W-1:0] typ, logic [CODE_W-1:0] code,
                        logic [VALUE_W-1:0] value);
        t_ev ev;
        ev = '{typ, code, value};
        send_event(ev, ROW_PREDICTED, '0);
    endtask

    // Write one register; valid stays up so writes can go back to back
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [SIZE_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (o_cfg_ready !== 1'b1) @(posedge i_clk);
        if (idx == CFG_SCREEN_WIDTH) begin
            screen_w = data;
        end else begin
            screen_h = data;
        end
    endtask

    task automatic write_screen(logic [SIZE_W-1:0] w, logic [SIZE_W-1:0] h);
        write_reg(CFG_SCREEN_WIDTH, w);
        write_reg(CFG_SCREEN_HEIGHT, h);
        i_cfg_valid <= 1'b0;
    endtask

    // Mostly in-range positions, with the clamp edges and wild values mixed in
    function automatic logic [VALUE_W-1:0] pick_axis_value();
        case ($urandom_range(7))
            0:       return $urandom;
            1:       return '0;
            2:       return AXIS_MAX_DEF;
            3:       return 32'h8000_0000 | $urandom;
            4:       return $urandom_range(32'h7FFF_FFFF, AXIS_MAX_DEF + 1);
            default: return $urandom_range(AXIS_MAX_DEF);
        endcase
    endfunction

    // One well-formed report: axes in random order, some keys, then the sync.
    // Without the sync it is a broken stroke whose state carries over.
    task automatic send_stroke(bit with_report);
        logic [CODE_W-1:0] axis;
        axis = $urandom_range(1) ? CODE_AXIS_X : CODE_AXIS_Y;
        repeat (2) begin
            if ($urandom_range(3) != 0) begin
                post(TYPE_ABS, axis, pick_axis_value());
            end
            axis = (axis == CODE_AXIS_X) ? CODE_AXIS_Y : CODE_AXIS_X;
        end
        repeat ($urandom_range(3)) begin
            post(TYPE_KEY, CODE_KEY_LEFT + CODE_W'($urandom_range(2)),
                 $urandom_range(1) ? $urandom : '0);
        end
        if (with_report) begin
            post(TYPE_SYN, CODE_REPORT, $urandom_range(1) ? '0 : $urandom);
        end
    endtask

    // Random junk: unknown types, and unknown or near-miss codes within known types
    task automatic send_noise();
        case ($urandom_range(3))
            0:       post(TYPE_W'($urandom), CODE_W'($urandom), $urandom);
            1:       post(TYPE_ABS, $urandom_range(1) ? CODE_W'($urandom)
                                                      : CODE_W'($urandom_range(3)), $urandom);
            2:       post(TYPE_KEY, $urandom_range(1) ? CODE_W'($urandom)
                                  : CODE_KEY_LEFT - CODE_W'(2) + CODE_W'($urandom_range(5)),
                          $urandom);
            default: post(TYPE_SYN, CODE_W'($urandom), $urandom);
        endcase
    endtask

    // Stop offering, wait for every owed report, then let the pipeline settle
    task automatic drain();
        i_valid <= 1'b0;
        while (reports_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_phase(logic [SIZE_W-1:0] w, logic [SIZE_W-1:0] h,
                             int unsigned gap, bit hold);
        int unsigned target;
        write_screen(w, h);
        gap_pct  = gap;
        hold_req = hold;
        target   = items_sent + ITEMS_PER_PHASE;
        // full-scale stroke first: hits the zero-size and saturation corners
        post(TYPE_ABS, CODE_AXIS_X, AXIS_MAX_DEF);
        post(TYPE_ABS, CODE_AXIS_Y, AXIS_MAX_DEF);
        post(TYPE_SYN, CODE_REPORT, '0);
        while (items_sent < target) begin
            case ($urandom_range(9))
                7:       repeat ($urandom_range(3, 1)) send_noise();
                8:       send_stroke(1'b0);
                9:       post(TYPE_SYN, CODE_REPORT, $urandom);
                default: send_stroke(1'b1);
            endcase
        end
        drain();
    endtask

    // Stimulus: reset, directed table, then random phases at several screen sizes
    initial begin
        t_ev     ev;
        t_report rep;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        gap_pct = 25;
        foreach (DIRECTED[r]) begin
            ev  = '{DIRECTED[r].typ, DIRECTED[r].code, DIRECTED[r].value};
            rep = '{DIRECTED[r].x, DIRECTED[r].y, DIRECTED[r].btn, DIRECTED[r].cmt};
            send_event(ev, DIRECTED[r].typed, rep);
        end
        drain();

        // Sender never idles here while the receiver holds off: the block must back up
        run_phase(14'd0, 14'h3FFF, 0, 1'b1);
        run_phase(14'd8192, 14'd1, 30, 1'b0);
        run_phase(14'd1, 14'd8192, 15, 1'b0);
        run_phase(SIZE_W'($urandom_range(8192, 1)), SIZE_W'($urandom_range(8192, 1)),
                  40, 1'b0);
        run_phase(14'h3FFF, 14'd0, 10, 1'b0);
        // Last stretch runs flat out on both sides
        calm = 1'b1;
        run_phase(RESET_WIDTH, RESET_HEIGHT, 0, 1'b0);

        if (mismatches == 0 && reports_due.size() == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

    // Receiver: random stall bursts, one long hold-off on request, none when calm
    initial begin
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (calm || $urandom_range(1)) begin
                i_stall <= 1'b0;
                repeat ($urandom_range(40, 1)) @(posedge i_clk);
            end else begin
                i_stall <= 1'b1;
                repeat ($urandom_range(14, 1)) @(posedge i_clk);
            end
        end
    end

    // Compare each taken report with the oldest one owed
    always @(posedge i_clk) begin : check_reports
        t_report due;
        if (i_rst_n && o_valid === 1'b1 && i_stall == 1'b0) begin
            if (reports_due.size() == 0) begin
                mismatches++;
                if (mismatches <= SHOWN_MISMATCH) begin
                    $display("unexpected report: x=%0d y=%0d btn=%0d cmt=%0d",
                             o_pos_x, o_pos_y, o_buttons, o_committed);
                end
            end else begin
                due = reports_due.pop_front();
                if (o_pos_x !== due.pos_x || o_pos_y !== due.pos_y ||
                    o_buttons !== due.buttons || o_committed !== due.committed) begin
                    mismatches++;
                    if (mismatches <= SHOWN_MISMATCH) begin
                        $display("report mismatch: exp x=%0d y=%0d btn=%0d cmt=%0d, %s",
                                 due.pos_x, due.pos_y, due.buttons, due.committed,
                                 $sformatf("got x=%0d y=%0d btn=%0d cmt=%0d",
                                           o_pos_x, o_pos_y, o_buttons, o_committed));
                    end
                end
            end
        end
    end

    // Watchdog: end the run if no channel moves for too long
    always @(posedge i_clk) begin
        if ((i_valid && o_stall === 1'b0) || (o_valid === 1'b1 && !i_stall) ||
            (i_cfg_valid && o_cfg_ready === 1'b1)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("testbench failed");
            $finish;
        end
    end

endmodule

[filelist.f]
hdl/tea_pkg.sv
hdl/tea_front.sv
hdl/tea_div.sv
hdl/tea_state.sv
hdl/tablet_event_accumulator_core.sv
tb/testbench.sv
